### rtl/core/hashed_set_assoc_lru_cache_core_macros.svh
// Assertion macros shared by the cache checker.
`ifndef HASHED_SET_ASSOC_LRU_CACHE_CORE_MACROS_SVH
`define HASHED_SET_ASSOC_LRU_CACHE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define HSALC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cache checker: implication failed");

// Next-cycle implication, disabled in reset.
`define HSALC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cache checker: next-cycle implication failed");

// Next-cycle implication that also holds across reset.
`define HSALC_ASSERT_RST(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cache checker: reset implication failed");

`endif

### rtl/core/hsalc_pkg.sv
// Package: operation codes and hash constants of the cache.
package hsalc_pkg;

  typedef enum logic [1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  localparam logic [31:0] HASH_MUL_X  = 32'h9e3779b9;
  localparam logic [31:0] HASH_MUL_Z  = 32'h85ebca6b;
  localparam logic [31:0] HASH_MUL_M1 = 32'h7feb352d;
  localparam logic [31:0] HASH_MUL_M2 = 32'h846ca68b;
  localparam int unsigned HASH_SH_A   = 16;
  localparam int unsigned HASH_SH_B   = 15;

  localparam logic [31:0] COUNT_MAX = 32'hffffffff;

endpackage

### rtl/core/hsalc_if.sv
// Interfaces: request and response channels of the cache.
interface hsalc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] seed_key;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_z;
  logic [63:0] payload_in;

  modport source (output valid, func, seed_key, coord_x, coord_z, payload_in, input ready);
  modport sink   (input valid, func, seed_key, coord_x, coord_z, payload_in, output ready);
endinterface

interface hsalc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [63:0] payload_out;
  logic [31:0] hit_count;
  logic [31:0] miss_count;

  modport source (output valid, hit, payload_out, hit_count, miss_count, input ready);
  modport sink   (input valid, hit, payload_out, hit_count, miss_count, output ready);
endinterface

### rtl/core/hsalc_ram.sv
// Generic single-port-write, registered-read RAM.
module hsalc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/core/hashed_set_assoc_lru_cache_core.sv
// Top level: hashed set-associative cache with stamp-based replacement.
//
//  channel | dir | payload                                      | accepted when
//  req     | in  | func, seed_key, coord_x, coord_z, payload_in | valid && ready
//  rsp     | out | hit, payload_out, hit_count, miss_count      | valid && ready
//
// Lookup/insert: the hash runs over three multiply stages, set reduction over
// two, then one set read, one read-modify-write step and the move into the
// output register. The next request is taken only once that move is done, so
// a request is not taken while the last one is still in flight.
// Clear and reset: a sweep over every set of the set memory, one set a
// cycle; no request is taken meanwhile. Reset ends with that sweep, no result.
// A finished result waits in the output register; the next request is taken
// while it waits, and the pipeline stalls only when a second result is ready.
module hashed_set_assoc_lru_cache_core #(
  parameter int NUM_SETS      = 512,
  parameter int NUM_WAYS      = 4,
  parameter int PAYLOAD_WIDTH = 64
) (
  input logic     clk,
  input logic     rst,
  hsalc_req_if.sink   req,
  hsalc_rsp_if.source rsp
);
  import hsalc_pkg::*;

  localparam int SET_W = $clog2(NUM_SETS);
  localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int RED_W = SET_W + 2;
  // Reciprocal for the modulo: quotient estimate is at most two short.
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_SETS);
  localparam logic [RED_W-1:0] SETS_1X = RED_W'(NUM_SETS);
  localparam logic [RED_W-1:0] SETS_2X = RED_W'(2 * NUM_SETS);

  typedef struct packed {
    logic                     valid;
    logic [31:0]              seed;
    logic [31:0]              x;
    logic [31:0]              z;
    logic [63:0]              stamp;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } way_t;

  typedef way_t [NUM_WAYS-1:0] row_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MIX1, S_MIX2, S_MIX3, S_RED1, S_RED2, S_READ, S_EVAL, S_EMIT, S_CLR
  } state_t;

  state_t state;

  // Latched request.
  func_t       func_q;
  logic [31:0] seed_q, x_q, z_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;

  // Hash and set reduction.
  logic [31:0]      hash;
  logic [31:0]      quot;
  logic [RED_W-1:0] rem;
  logic [SET_W-1:0] set_idx;
  logic [SET_W-1:0] clr_addr;
  logic             clr_resp;

  // Global counters.
  logic [63:0] stamp_cnt;
  logic [31:0] hits, misses;

  // Result waiting for the output register.
  logic        res_hit;
  logic [63:0] res_pay;
  logic [31:0] res_hits, res_misses;

  // Output register.
  logic        out_valid;
  logic        out_hit;
  logic [63:0] out_pay;
  logic [31:0] out_hits, out_misses;

  // Memory port.
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr, ram_raddr;
  row_t             ram_wdata, ram_rdata;
  logic [$bits(row_t)-1:0] ram_rbits;

  hsalc_ram #(.WIDTH($bits(row_t)), .DEPTH(NUM_SETS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );
  assign ram_rdata = row_t'(ram_rbits);

  // Combinational datapath pieces.
  logic [31:0]      mix0, mix1_in, mix2_in, fin;
  logic [RED_W-1:0] rem_corr;
  logic [63:0]      fresh, stamp_inc;
  logic             found;
  logic [WAY_W-1:0] hit_way, victim, sel_way;
  row_t             row_upd;
  logic             out_free;

  always_comb begin
    mix0    = seed_q ^ 32'(x_q * HASH_MUL_X) ^ 32'(z_q * HASH_MUL_Z);
    mix1_in = hash ^ (hash >> HASH_SH_A);
    mix2_in = hash ^ (hash >> HASH_SH_B);
    fin     = hash ^ (hash >> HASH_SH_A);
    // Fold the remainder back below the set count.
    if (rem >= SETS_2X) begin
      rem_corr = rem - SETS_2X;
    end else if (rem >= SETS_1X) begin
      rem_corr = rem - SETS_1X;
    end else begin
      rem_corr = rem;
    end
    stamp_inc = stamp_cnt + 64'd1;
    fresh     = (stamp_inc == 64'd0) ? 64'd1 : stamp_inc;
  end

  // Way match and victim scan; an invalid way always carries stamp zero.
  always_comb begin
    found   = 1'b0;
    hit_way = '0;
    victim  = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (ram_rdata[w].valid && ram_rdata[w].seed == seed_q &&
          ram_rdata[w].x == x_q && ram_rdata[w].z == z_q) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (!ram_rdata[w].valid || ram_rdata[w].stamp < ram_rdata[victim].stamp) begin
        victim = WAY_W'(w);
      end
    end
    sel_way = found ? hit_way : victim;
    row_upd = ram_rdata;
    if (func_q == FUNC_INSERT) begin
      row_upd[sel_way].valid   = 1'b1;
      row_upd[sel_way].seed    = seed_q;
      row_upd[sel_way].x       = x_q;
      row_upd[sel_way].z       = z_q;
      row_upd[sel_way].stamp   = fresh;
      row_upd[sel_way].payload = pay_q;
    end else if (found) begin
      row_upd[hit_way].stamp = fresh;
    end
  end

  always_comb begin
    ram_raddr = rem_corr[SET_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = set_idx;
    ram_wdata = row_upd;
    if (state == S_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (state == S_EVAL) begin
      ram_we = (func_q == FUNC_INSERT) || found;
    end
  end

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  assign rsp.valid       = out_valid;
  assign rsp.hit         = out_hit;
  assign rsp.payload_out = out_pay;
  assign rsp.hit_count   = out_hits;
  assign rsp.miss_count  = out_misses;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      clr_resp  <= 1'b0;
      stamp_cnt <= '0;
      hits      <= '0;
      misses    <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the shown result once it is taken, unless a new one replaces it.
      if (out_valid && rsp.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_q <= func_t'(req.func);
            seed_q <= req.seed_key;
            x_q    <= req.coord_x;
            z_q    <= req.coord_z;
            pay_q  <= req.payload_in[PAYLOAD_WIDTH-1:0];
            unique case (func_t'(req.func))
              FUNC_LOOKUP, FUNC_INSERT: state <= S_MIX1;
              FUNC_CLEAR: begin
                stamp_cnt <= '0;
                hits      <= '0;
                misses    <= '0;
                clr_addr  <= '0;
                clr_resp  <= 1'b1;
                state     <= S_CLR;
              end
              FUNC_NONE: begin
                res_hit    <= 1'b0;
                res_pay    <= '0;
                res_hits   <= hits;
                res_misses <= misses;
                state      <= S_EMIT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_MIX1: begin
          hash  <= mix0;
          state <= S_MIX2;
        end
        S_MIX2: begin
          hash  <= 32'(mix1_in * HASH_MUL_M1);
          state <= S_MIX3;
        end
        S_MIX3: begin
          hash  <= 32'(mix2_in * HASH_MUL_M2);
          state <= S_RED1;
        end
        S_RED1: begin
          hash  <= fin;
          quot  <= 32'((64'(fin) * 64'(RECIP)) >> 32);
          state <= S_RED2;
        end
        S_RED2: begin
          rem   <= RED_W'(hash - 32'(quot * 32'(NUM_SETS)));
          state <= S_READ;
        end
        S_READ: begin
          // Read is issued from rem_corr at this edge.
          set_idx <= rem_corr[SET_W-1:0];
          state   <= S_EVAL;
        end
        S_EVAL: begin
          res_hit  <= found;
          res_pay  <= (func_q == FUNC_LOOKUP && found)
                      ? 64'(ram_rdata[hit_way].payload) : 64'd0;
          res_hits   <= hits;
          res_misses <= misses;
          if (func_q == FUNC_INSERT || found) begin
            stamp_cnt <= fresh;
          end
          if (func_q == FUNC_LOOKUP) begin
            if (found) begin
              if (hits != COUNT_MAX) begin
                hits     <= hits + 32'd1;
                res_hits <= hits + 32'd1;
              end
            end else if (misses != COUNT_MAX) begin
              misses     <= misses + 32'd1;
              res_misses <= misses + 32'd1;
            end
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          // Hold until the output register is free; a stalled result stays valid.
          if (out_free) begin
            out_valid  <= 1'b1;
            out_hit    <= res_hit;
            out_pay    <= res_pay;
            out_hits   <= res_hits;
            out_misses <= res_misses;
            state      <= S_IDLE;
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + SET_W'(1);
          if (clr_addr == SET_W'(NUM_SETS - 1)) begin
            res_hit    <= 1'b0;
            res_pay    <= '0;
            res_hits   <= '0;
            res_misses <= '0;
            clr_resp   <= 1'b0;
            state      <= clr_resp ? S_EMIT : S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/core/hsalc_checker.sv
// Checker: port-level properties of the cache, bound to the top level.
`include "hashed_set_assoc_lru_cache_core_macros.svh"

module hsalc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        rsp_hit,
  input logic [63:0] rsp_payload_out,
  input logic [31:0] rsp_hit_count,
  input logic [31:0] rsp_miss_count
);
  `HSALC_ASSERT_IMP(a_miss_zero_payload, clk, rst, rsp_valid && !rsp_hit, rsp_payload_out == 64'd0)
  `HSALC_ASSERT_NXT(a_stall_holds, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload_out) && $stable(rsp_hit_count))
  `HSALC_ASSERT_RST(a_reset_quiet, clk, rst, !rsp_valid)
  `HSALC_ASSERT_NXT(a_hit_clears_zero, clk, rst, rsp_valid && rsp_ready && rsp_hit && rsp_payload_out == 64'd0 && rsp_hit_count == 32'd0 && rsp_miss_count == 32'd0, 1'b1)
endmodule

bind hashed_set_assoc_lru_cache_core hsalc_checker u_hsalc_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_hit         (rsp.hit),
  .rsp_payload_out (rsp.payload_out),
  .rsp_hit_count   (rsp.hit_count),
  .rsp_miss_count  (rsp.miss_count)
);

### bench/hsalc_tb_pkg.sv
`timescale 1ns / 1ps
// Predictor of the cache: set storage, replacement and saturating counters.
package hsalc_tb_pkg;
  import hsalc_pkg::*;

  localparam int SETS = 512;
  localparam int WAYS = 4;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] seed_key;
    logic [31:0] coord_x;
    logic [31:0] coord_z;
    logic [63:0] payload_in;
  } cache_req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] payload_out;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
  } cache_rsp_t;

  logic        line_valid [SETS*WAYS];
  logic [31:0] line_seed  [SETS*WAYS];
  logic [31:0] line_x     [SETS*WAYS];
  logic [31:0] line_z     [SETS*WAYS];
  logic [63:0] line_stamp [SETS*WAYS];
  logic [63:0] line_data  [SETS*WAYS];
  logic [63:0] age_clock;
  logic [31:0] hits_so_far;
  logic [31:0] misses_so_far;

  function automatic void wipe_cache();
    for (int i = 0; i < SETS*WAYS; i++) begin
      line_valid[i] = 1'b0;
      line_stamp[i] = '0;
    end
    age_clock = '0;
    hits_so_far = '0;
    misses_so_far = '0;
  endfunction

  function automatic logic [31:0] mix_key(logic [31:0] s, logic [31:0] x, logic [31:0] z);
    logic [31:0] h;
    h = s ^ (x * 32'h9e3779b9) ^ (z * 32'h85ebca6b);
    h = h ^ (h >> 16);
    h = h * 32'h7feb352d;
    h = h ^ (h >> 15);
    h = h * 32'h846ca68b;
    return h ^ (h >> 16);
  endfunction

  function automatic logic [63:0] next_age();
    age_clock = age_clock + 64'd1;
    if (age_clock == '0) age_clock = 64'd1;
    return age_clock;
  endfunction

  function automatic cache_rsp_t apply_request(cache_req_t rq);
    cache_rsp_t r;
    int base, e, victim;
    logic found;
    r = '0;
    found = 1'b0;
    base = int'(mix_key(rq.seed_key, rq.coord_x, rq.coord_z) % SETS) * WAYS;
    victim = base;
    e = base;
    if (rq.func == FUNC_LOOKUP || rq.func == FUNC_INSERT) begin
      for (int w = 0; w < WAYS; w++) begin
        if (!found) begin
          if (line_valid[base+w] && line_seed[base+w] == rq.seed_key &&
              line_x[base+w] == rq.coord_x && line_z[base+w] == rq.coord_z) begin
            found = 1'b1;
            e = base + w;
          end else if (!line_valid[base+w] || line_stamp[base+w] < line_stamp[victim]) begin
            victim = base + w;
          end
        end
      end
      if (!found) e = victim;
    end
    case (rq.func)
      FUNC_LOOKUP: begin
        if (found) begin
          r.payload_out = line_data[e];
          line_stamp[e] = next_age();
          if (hits_so_far != COUNT_MAX) hits_so_far++;
        end else if (misses_so_far != COUNT_MAX) misses_so_far++;
        r.hit = found;
      end
      FUNC_INSERT: begin
        line_valid[e] = 1'b1;
        line_seed[e]  = rq.seed_key;
        line_x[e]     = rq.coord_x;
        line_z[e]     = rq.coord_z;
        line_stamp[e] = next_age();
        line_data[e]  = rq.payload_in;
        r.hit = found;
      end
      FUNC_CLEAR: wipe_cache();
      default: ;
    endcase
    r.hit_count = hits_so_far;
    r.miss_count = misses_so_far;
    return r;
  endfunction
endpackage

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the bench: stimulus, idling, result checking and end of run.
module testbench;
  import hsalc_pkg::*;
  import hsalc_tb_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  hsalc_req_if req ();
  hsalc_rsp_if rsp ();

  hashed_set_assoc_lru_cache_core dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Directed rows: a request plus, where obvious, the expected response.
  typedef struct {
    cache_req_t rq;
    bit         typed;
    cache_rsp_t rs;
  } row_t;

  cache_rsp_t pending_rsp [$];
  int  errors = 0;
  int  send_idle_pct = 6;
  int  recv_stall_pct = 62;
  longint cycle_count = 0;
  // Recently inserted keys, so lookups hit and sets fill up.
  logic [95:0] known_keys [$];

  // Count cycles; stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("status: fail");
      $finish;
    end
  end

  // Stall the response side at random; never idle when the rate is zero.
  initial rsp.ready = 1'b0;
  always @(posedge clk) rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

  // Check each accepted response against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response transaction");
        errors++;
      end else begin
        cache_rsp_t e;
        e = pending_rsp.pop_front();
        if (rsp.hit !== e.hit) begin
          $error("hit: expected %0h actual %0h", e.hit, rsp.hit); errors++;
        end
        if (rsp.payload_out !== e.payload_out) begin
          $error("payload_out: expected %0h actual %0h", e.payload_out, rsp.payload_out);
          errors++;
        end
        if (rsp.hit_count !== e.hit_count) begin
          $error("hit_count: expected %0h actual %0h", e.hit_count, rsp.hit_count);
          errors++;
        end
        if (rsp.miss_count !== e.miss_count) begin
          $error("miss_count: expected %0h actual %0h", e.miss_count, rsp.miss_count);
          errors++;
        end
      end
    end
  end

  // Drive one request transaction, idling first at random; queue its prediction.
  // Valid stays high after the accepting edge; the next call or drain drops it.
  task automatic send_request(cache_req_t rq, bit typed, cache_rsp_t typed_rs);
    cache_rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.func       <= rq.func;
    req.seed_key   <= rq.seed_key;
    req.coord_x    <= rq.coord_x;
    req.coord_z    <= rq.coord_z;
    req.payload_in <= rq.payload_in;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    p = apply_request(rq);
    if (typed && p !== typed_rs) begin
      $error("directed row: predictor disagrees with typed response");
      errors++;
    end
    pending_rsp.push_back(p);
    if (rq.func == FUNC_INSERT) begin
      known_keys.push_back({rq.seed_key, rq.coord_x, rq.coord_z});
      if (known_keys.size() > 48) void'(known_keys.pop_front());
    end
  endtask

  function automatic cache_req_t random_request();
    cache_req_t rq;
    int k;
    rq.func = ($urandom_range(99) < 45) ? FUNC_LOOKUP : FUNC_INSERT;
    if ($urandom_range(99) < 2) rq.func = FUNC_CLEAR;
    if ($urandom_range(99) < 2) rq.func = FUNC_NONE;
    rq.payload_in = {$urandom, $urandom};
    if (known_keys.size() > 0 && $urandom_range(99) < 55) begin
      k = $urandom_range(known_keys.size() - 1);
      {rq.seed_key, rq.coord_x, rq.coord_z} = known_keys[k];
    end else begin
      // Small seeds reuse keys and crowd sets; wide values flip every bit.
      rq.seed_key = $urandom_range(99) < 50 ? $urandom_range(7) : $urandom;
      rq.coord_x  = $urandom_range(99) < 50 ? $urandom_range(15) - 8 : $urandom;
      rq.coord_z  = $urandom_range(99) < 50 ? $urandom_range(15) - 8 : $urandom;
    end
    return rq;
  endfunction

  // Drop valid, then wait until every expected response has come back.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  row_t rows [$];

  initial begin
    cache_req_t rq;
    row_t r;
    req.valid = 1'b0;
    req.func = FUNC_NONE;
    req.seed_key = '0;
    req.coord_x = '0;
    req.coord_z = '0;
    req.payload_in = '0;
    wipe_cache();

    // Lookup on an empty cache misses; an insert after reset misses.
    rows.push_back('{'{FUNC_LOOKUP, 32'h0, 32'h0, 32'h0, 64'h0}, 1, '{0, 0, 0, 1}});
    rows.push_back('{'{FUNC_INSERT, 32'hffffffff, 32'h80000000, 32'h7fffffff,
                      64'hffffffffffffffff}, 1, '{0, 0, 0, 1}});
    rows.push_back('{'{FUNC_LOOKUP, 32'hffffffff, 32'h80000000, 32'h7fffffff, 64'h0},
                     1, '{1, 64'hffffffffffffffff, 1, 1}});
    rows.push_back('{'{FUNC_INSERT, 32'h0, 32'h7fffffff, 32'h80000000, 64'h0}, 0, '0});
    rows.push_back('{'{FUNC_INSERT, 32'h0, 32'h7fffffff, 32'h80000000,
                      64'h0123456789abcdef}, 0, '0});
    rows.push_back('{'{FUNC_LOOKUP, 32'h0, 32'h7fffffff, 32'h80000000, 64'h0}, 0, '0});
    rows.push_back('{'{FUNC_NONE, 32'h5, 32'h6, 32'h7, 64'h8}, 1,
                     '{0, 0, 2, 1}});
    // Insert and look up five keys in turn; the same set is not forced, so no set is sure to fill past its ways.
    for (int i = 0; i < 10; i++)
      rows.push_back('{'{i[0] ? FUNC_LOOKUP : FUNC_INSERT, 32'h1, i / 2, -1,
                        {32'hdead0000, i}}, 0, '0});
    rows.push_back('{'{FUNC_CLEAR, 32'h0, 32'h0, 32'h0, 64'h0}, 1, '0});
    rows.push_back('{'{FUNC_LOOKUP, 32'hffffffff, 32'h80000000, 32'h7fffffff, 64'h0},
                     1, '{0, 0, 0, 1}});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_request(rows[i].rq, rows[i].typed, rows[i].rs);
    // Hold off until the block has answered everything.
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 62 : 0;
      recv_stall_pct = (phase == 0) ? 62 : (phase == 1) ? 6 : 0;
      repeat (670) begin
        rq = random_request();
        send_request(rq, 0, '0);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
